[rtl/cws_pkg.sv]
// Shared types, constants and helpers for the circular window sum block.
package cws_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int ELEM_W           = 32;
  localparam int SUM_W            = 64;
  localparam int LEN_W            = 32;
  localparam int MUL_CNT_W        = $clog2(LEN_W);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_PRE_RD,
    ST_PRE_ADD,
    ST_EMIT,
    ST_SUB_RD,
    ST_SUB,
    ST_ADD_RD,
    ST_ADD
  } state_t;

  function automatic logic [SUM_W-1:0] sext(input logic [ELEM_W-1:0] v);
    return {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
  endfunction

endpackage

[rtl/cws_if.sv]
// Handshake channels for element input, window sum output and length writes.
interface cws_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [cws_pkg::ELEM_W-1:0] element_value;
  logic                              is_last;
  modport source (output valid, element_value, is_last, input ready);
  modport sink   (input valid, element_value, is_last, output ready);
endinterface

interface cws_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cws_pkg::SUM_W-1:0] window_sum;
  logic                             last_sum;
  logic                             overflow_flag;
  modport source (output valid, window_sum, last_sum, overflow_flag, input ready);
  modport sink   (input valid, window_sum, last_sum, overflow_flag, output ready);
endinterface

interface cws_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cws_pkg::LEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/cws_mem.sv]
// Element store: one write port, one registered read port.
module cws_mem #(
  parameter int DEPTH = cws_pkg::MAX_ELEMENTS_DEF,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cws_pkg::ELEM_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [cws_pkg::ELEM_W-1:0] rdata
);

  logic [cws_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cws_div.sv]
// Restoring divider, one quotient bit per cycle, for length / element count.
module cws_div #(
  parameter int CW = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cws_pkg::LEN_W-1:0] dividend,
  input  logic [CW-1:0]             divisor,
  output logic                      done,
  output logic [cws_pkg::LEN_W-1:0] quotient,
  output logic [CW-1:0]             remainder
);

  localparam int LW    = cws_pkg::LEN_W;
  localparam int MUL_W = cws_pkg::MUL_CNT_W;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_W-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        div_r, div_nxt;
  logic [CW:0]          trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[LW-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[LW-2:0], ge};
      rem_nxt = ge ? CW'(trial - {1'b0, div_r}) : trial[CW-1:0];
      cnt_nxt = cnt_r + MUL_W'(1);
      if (cnt_r == MUL_W'(LW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/circular_window_sum_top.sv]
// Circular window sum top: loads a vector, then emits one cyclic window sum per position.
// Elements load at one per cycle. The item with is_last closes the vector and starts
// the closing pass, during which no item is accepted: the divider forms window_length / n
// for n stored elements, a shift-and-add multiply scales the vector total by the
// quotient, the first (window_length % n) elements are added as the remainder prefix,
// then each result is emitted and followed by a subtract and an add through the single
// store read port, except the last result, which is only emitted. Every sum goes
// through one shared 64-bit adder. Results sit in an output register, so the pass
// stalls only when a result is still waiting to be taken.
module circular_window_sum_top #(
  parameter int MAX_ELEMENTS = cws_pkg::MAX_ELEMENTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cws_in_if.sink    in_chan,
  cws_out_if.source out_chan,
  cws_cfg_if.sink   cfg_chan
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = cws_pkg::SUM_W;
  localparam int EW = cws_pkg::ELEM_W;
  localparam int LW = cws_pkg::LEN_W;
  localparam int MW = cws_pkg::MUL_CNT_W;

  cws_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] tot_r, tot_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          too_long_r, too_long_nxt;
  logic [LW-1:0] len_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [LW-1:0] p_r, p_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [MW-1:0] mcnt_r, mcnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_flag_r, out_flag_nxt;

  logic          in_acc, has_room, last_pos, out_free, emit_go;
  logic          div_start, div_done;
  logic [LW-1:0] div_quo;
  logic [CW-1:0] div_rem;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [CW:0]   enter_t, enter_w;

  logic [SW-1:0] add_a, add_b, add_y;
  logic          add_sub;

  assign in_chan.ready  = (state_r == cws_pkg::ST_LOAD);
  assign in_acc         = in_chan.valid & in_chan.ready;
  assign has_room       = cnt_r < CW'(MAX_ELEMENTS);
  assign cfg_chan.ready = 1'b1;
  assign last_pos       = idx_r == (n_r - CW'(1));
  assign out_free       = !out_valid_r || out_chan.ready;
  assign emit_go        = (state_r == cws_pkg::ST_EMIT) && out_free;
  assign div_start      = in_acc && in_chan.is_last;

  assign enter_t = {1'b0, idx_r} + {1'b0, r_r} - (CW + 1)'(1);
  assign enter_w = (enter_t >= {1'b0, n_r}) ? (enter_t - {1'b0, n_r}) : enter_t;

  cws_mem #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (in_acc && has_room),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_chan.element_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cws_div #(
    .CW (CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (len_r),
    .divisor   (n_nxt),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // shared adder
  always_comb begin
    add_a   = sum_r;
    add_b   = cws_pkg::sext(rd_data);
    add_sub = 1'b0;
    unique case (state_r)
      cws_pkg::ST_LOAD: begin
        add_a = tot_r;
        add_b = cws_pkg::sext(in_chan.element_value);
      end
      cws_pkg::ST_MUL: begin
        add_a = {sum_r[SW-2:0], 1'b0};
        add_b = p_r[LW-1] ? tot_r : '0;
      end
      cws_pkg::ST_SUB: begin
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign add_y = add_a + (add_b ^ {SW{add_sub}}) + SW'(add_sub);

  always_comb begin
    unique case (state_r)
      cws_pkg::ST_SUB_RD: rd_addr = AW'(idx_r - CW'(1));
      cws_pkg::ST_ADD_RD: rd_addr = enter_w[AW-1:0];
      default:            rd_addr = idx_r[AW-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cws_pkg::ST_LOAD: begin
        if (div_start) begin
          state_nxt = cws_pkg::ST_DIV;
        end
      end
      cws_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = cws_pkg::ST_MUL;
        end
      end
      cws_pkg::ST_MUL: begin
        if (mcnt_r == MW'(LW - 1)) begin
          state_nxt = (r_r == '0) ? cws_pkg::ST_EMIT : cws_pkg::ST_PRE_RD;
        end
      end
      cws_pkg::ST_PRE_RD:  state_nxt = cws_pkg::ST_PRE_ADD;
      cws_pkg::ST_PRE_ADD: begin
        if ((idx_r + CW'(1)) == r_r) begin
          state_nxt = cws_pkg::ST_EMIT;
        end else begin
          state_nxt = cws_pkg::ST_PRE_RD;
        end
      end
      cws_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = last_pos ? cws_pkg::ST_LOAD : cws_pkg::ST_SUB_RD;
        end
      end
      cws_pkg::ST_SUB_RD: state_nxt = cws_pkg::ST_SUB;
      cws_pkg::ST_SUB:    state_nxt = cws_pkg::ST_ADD_RD;
      cws_pkg::ST_ADD_RD: state_nxt = cws_pkg::ST_ADD;
      cws_pkg::ST_ADD:    state_nxt = cws_pkg::ST_EMIT;
      default:            state_nxt = cws_pkg::ST_LOAD;
    endcase
  end

  // datapath updates
  always_comb begin
    cnt_nxt       = cnt_r;
    tot_nxt       = tot_r;
    sum_nxt       = sum_r;
    too_long_nxt  = too_long_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    mcnt_nxt      = mcnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;
    out_flag_nxt  = out_flag_r;
    unique case (state_r)
      cws_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_nxt = cnt_r + CW'(1);
            tot_nxt = add_y;
          end else begin
            too_long_nxt = 1'b1;
          end
          n_nxt = has_room ? (cnt_r + CW'(1)) : cnt_r;
        end
      end
      cws_pkg::ST_DIV: begin
        if (div_done) begin
          p_nxt    = div_quo;
          r_nxt    = div_rem;
          sum_nxt  = '0;
          mcnt_nxt = '0;
          idx_nxt  = '0;
        end
      end
      cws_pkg::ST_MUL: begin
        sum_nxt  = add_y;
        p_nxt    = {p_r[LW-2:0], 1'b0};
        mcnt_nxt = mcnt_r + MW'(1);
      end
      cws_pkg::ST_PRE_ADD: begin
        sum_nxt = add_y;
        idx_nxt = ((idx_r + CW'(1)) == r_r) ? '0 : (idx_r + CW'(1));
      end
      cws_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_last_nxt  = last_pos;
          out_flag_nxt  = too_long_r;
          if (last_pos) begin
            cnt_nxt      = '0;
            tot_nxt      = '0;
            too_long_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      cws_pkg::ST_SUB, cws_pkg::ST_ADD: begin
        sum_nxt = add_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cws_pkg::ST_LOAD;
      cnt_r       <= '0;
      tot_r       <= '0;
      too_long_r  <= 1'b0;
      len_r       <= cws_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tot_r       <= tot_nxt;
      too_long_r  <= too_long_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        len_r <= cfg_chan.data;
      end
    end
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    mcnt_r     <= mcnt_nxt;
    idx_r      <= idx_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.window_sum    = out_sum_r;
  assign out_chan.last_sum      = out_last_r;
  assign out_chan.overflow_flag = out_flag_r;

endmodule
